// ===== hdl/rbf_pkg.sv =====
// Package for the Gaussian RBF kernel block.
// Holds widths, the back-end state type, queue types and the exp2 coefficient functions.
// No dependencies.
package rbf_pkg;

   localparam int ELEM_W                 = 16;
   localparam int SQ_W                   = 32;
   localparam int ACC_W                  = 48;
   localparam int INV_W                  = 32;
   localparam int KV_W                   = 17;
   localparam int X_RANGE_BIT            = 20;
   localparam int QUEUE_DEPTH            = 4;
   localparam int EXP_TABLE_BITS_DEFAULT = 8;
   localparam logic [INV_W-1:0] INV_WIDTH_RESET = 32'h0001_0000;
   localparam logic [30:0]      LOG2E_Q30       = 31'd1549082005;
   localparam logic [KV_W-1:0]  KV_ONE          = 17'h1_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SCALE,
      ST_EXPO,
      ST_STEP,
      ST_ROUND
   } back_state_type;

   typedef struct packed {
      logic             valid;
      logic [ACC_W-1:0] distance;
   } q_push_type;

   typedef struct packed {
      logic not_empty;
      logic room;
   } q_status_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Coefficient c_idx approximates 2^-(2^-idx) in Q0.32.
   function automatic logic [31:0] exp_coef(input int idx);
      logic [63:0] c;
      c = 64'h0000_0000_8000_0000;
      for (int j = 1; j <= idx; j++) begin
         c = isqrt64(c << 32);
      end
      return c[31:0];
   endfunction

endpackage

// ===== hdl/rbf_if.sv =====
// Channel interfaces for the Gaussian RBF kernel block: element pairs in, kernel values out.
// Depends on rbf_pkg.
interface rbf_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [rbf_pkg::ELEM_W-1:0] elem_a;
   logic signed [rbf_pkg::ELEM_W-1:0] elem_b;
   logic                              last;

   modport source (output valid, elem_a, elem_b, last, input ready);
   modport sink (input valid, elem_a, elem_b, last, output ready);
endinterface

interface rbf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rbf_pkg::KV_W-1:0]   kernel_value;

   modport source (output valid, kernel_value, input ready);
   modport sink (input valid, kernel_value, output ready);
endinterface

// ===== hdl/rbf_front.sv =====
// Front end: accepts element pairs, squares the difference and accumulates with saturation.
// On the last pair it pushes the distance into the queue. Depends on rbf_pkg and rbf_if.
module rbf_front (
   input  logic                  clock,
   input  logic                  reset,
   rbf_req_if.sink               req_chan,
   input  rbf_pkg::q_status_type q_status,
   output rbf_pkg::q_push_type   q_push
);

   logic                         accept;
   logic signed [rbf_pkg::ELEM_W:0] diff;
   logic [rbf_pkg::ELEM_W:0]     mag_full;
   logic [rbf_pkg::ELEM_W-1:0]   mag;
   logic [rbf_pkg::ACC_W:0]      sum;
   logic [rbf_pkg::ACC_W-1:0]    acc_sat;

   logic                         vld_ff, vld_in;
   logic                         last_ff, last_in;
   logic [rbf_pkg::SQ_W-1:0]     sq_ff, sq_in;
   logic [rbf_pkg::ACC_W-1:0]    acc_ff, acc_in;

   assign req_chan.ready = q_status.room;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      diff = {req_chan.elem_a[rbf_pkg::ELEM_W-1], req_chan.elem_a}
           - {req_chan.elem_b[rbf_pkg::ELEM_W-1], req_chan.elem_b};
      mag_full = diff[rbf_pkg::ELEM_W] ? (~diff + 1'b1) : diff;
      mag = mag_full[rbf_pkg::ELEM_W-1:0];
      vld_in = accept;
      last_in = req_chan.last;
      sq_in = mag * mag;
   end

   always_comb begin
      sum = {1'b0, acc_ff} + {{(rbf_pkg::ACC_W-rbf_pkg::SQ_W+1){1'b0}}, sq_ff};
      acc_sat = sum[rbf_pkg::ACC_W] ? {rbf_pkg::ACC_W{1'b1}} : sum[rbf_pkg::ACC_W-1:0];
      acc_in = acc_ff;
      if (vld_ff) begin
         acc_in = last_ff ? '0 : acc_sat;
      end
      q_push.valid = vld_ff && last_ff;
      q_push.distance = acc_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= last_in;
         sq_ff <= sq_in;
      end
   end

   a_acc_clears: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && last_ff) |=> (acc_ff == '0))
      else $error("accumulator not cleared after a vector end");

endmodule

// ===== hdl/rbf_queue.sv =====
// Short distance queue between the front end and the back end.
// Depends on rbf_pkg.
module rbf_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  rbf_pkg::q_push_type         q_push,
   input  logic                        pop,
   output rbf_pkg::q_status_type       q_status,
   output logic [rbf_pkg::ACC_W-1:0]   head
);

   localparam int DEPTH = rbf_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [rbf_pkg::ACC_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   always_comb begin
      wr_ptr_in = q_push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (q_push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_push.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
      q_status.not_empty = (count_ff != '0);
      q_status.room = (count_ff <= CNT_W'(DEPTH - 2));
      head = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         entry_ff[wr_ptr_ff] <= q_push.distance;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push.valid |-> (count_ff < CNT_W'(DEPTH) || pop))
      else $error("distance queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("distance queue underflow");

endmodule

// ===== hdl/rbf_back.sv =====
// Back end: scales a distance by the inverse width and evaluates exp(-x) as 2^-(x*log2 e).
// A sequencer does at most one multiply per state. Depends on rbf_pkg and rbf_if.
module rbf_back #(
   parameter int EXP_TABLE_BITS = rbf_pkg::EXP_TABLE_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rbf_pkg::INV_W-1:0]   inv_width,
   input  rbf_pkg::q_status_type       q_status,
   input  logic [rbf_pkg::ACC_W-1:0]   head,
   output logic                        pop,
   rbf_rsp_if.source                   rsp_chan
);

   localparam int CNT_W  = $clog2(EXP_TABLE_BITS);
   localparam int HALF_W = rbf_pkg::ACC_W / 2;
   localparam int PROD_W = HALF_W + rbf_pkg::INV_W;
   localparam int X_W    = PROD_W + 1;

   logic [31:0] coef_w [EXP_TABLE_BITS];

   for (genvar gi = 0; gi < EXP_TABLE_BITS; gi++) begin : g_coef
      localparam logic [31:0] COEF = rbf_pkg::exp_coef(gi + 1);
      assign coef_w[gi] = COEF;
   end

   rbf_pkg::back_state_type state_ff, state_in;

   logic [rbf_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [PROD_W-1:0]           prod_lo_ff, prod_lo_in;
   logic [PROD_W-1:0]           prod_hi_ff, prod_hi_in;
   logic                        zero_ff, zero_in;
   logic [rbf_pkg::X_RANGE_BIT-1:0] xq_ff, xq_in;
   logic [4:0]                  n_ff, n_in;
   logic [EXP_TABLE_BITS-1:0]   k_ff, k_in;
   logic [32:0]                 p_ff, p_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [rbf_pkg::KV_W-1:0]    kernel_ff, kernel_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [X_W-1:0]              x_sum;
   logic [50:0]                 y_prod;
   logic [64:0]                 step_prod;
   logic [65:0]                 step_rnd;
   logic [33:0]                 entry_rnd;
   logic [rbf_pkg::KV_W-1:0]    entry;
   logic                        out_free;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kernel_value = kernel_ff;

   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;
      prod_lo_in = prod_lo_ff;
      prod_hi_in = prod_hi_ff;
      zero_in = zero_ff;
      xq_in = xq_ff;
      n_in = n_ff;
      k_in = k_ff;
      p_in = p_ff;
      cnt_in = cnt_ff;
      kernel_in = kernel_ff;
      pop = 1'b0;
      out_free = !rsp_valid_ff || rsp_chan.ready;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      x_sum = {1'b0, prod_hi_ff} + X_W'(prod_lo_ff[PROD_W-1:HALF_W]);
      y_prod = xq_ff * rbf_pkg::LOG2E_Q30;
      step_prod = p_ff * coef_w[cnt_ff];
      step_rnd = {1'b0, step_prod} + 66'h0_8000_0000;
      entry_rnd = {1'b0, p_ff} + 34'h0_0000_8000;
      entry = entry_rnd[32:16];

      case (state_ff)
         rbf_pkg::ST_IDLE: begin
            if (q_status.not_empty) begin
               pop = 1'b1;
               acc_in = head;
               state_in = rbf_pkg::ST_MUL_LO;
            end
         end
         rbf_pkg::ST_MUL_LO: begin
            prod_lo_in = acc_ff[HALF_W-1:0] * inv_width;
            state_in = rbf_pkg::ST_MUL_HI;
         end
         rbf_pkg::ST_MUL_HI: begin
            prod_hi_in = acc_ff[rbf_pkg::ACC_W-1:HALF_W] * inv_width;
            state_in = rbf_pkg::ST_SCALE;
         end
         rbf_pkg::ST_SCALE: begin
            zero_in = |x_sum[X_W-1:rbf_pkg::X_RANGE_BIT];
            xq_in = x_sum[rbf_pkg::X_RANGE_BIT-1:0];
            state_in = rbf_pkg::ST_EXPO;
         end
         rbf_pkg::ST_EXPO: begin
            n_in = y_prod[50:46];
            k_in = y_prod[45 -: EXP_TABLE_BITS];
            p_in = 33'h1_0000_0000;
            cnt_in = '0;
            state_in = rbf_pkg::ST_STEP;
         end
         rbf_pkg::ST_STEP: begin
            if (k_ff[EXP_TABLE_BITS-1]) begin
               p_in = step_rnd[64:32];
            end
            k_in = k_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(EXP_TABLE_BITS - 1)) begin
               state_in = rbf_pkg::ST_ROUND;
            end
         end
         rbf_pkg::ST_ROUND: begin
            if (out_free) begin
               kernel_in = zero_ff ? '0 : (entry >> n_ff);
               rsp_valid_in = 1'b1;
               state_in = rbf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      zero_ff <= zero_in;
      xq_ff <= xq_in;
      n_ff <= n_in;
      k_ff <= k_in;
      p_ff <= p_in;
      cnt_ff <= cnt_in;
      kernel_ff <= kernel_in;
   end

   a_kernel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (kernel_ff <= rbf_pkg::KV_ONE))
      else $error("kernel value above 1.0");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == rbf_pkg::ST_IDLE && q_status.not_empty))
      else $error("queue popped outside idle");

endmodule

// ===== hdl/gaussian_rbf_kernel.sv =====
// Gaussian RBF kernel: one element pair accepted per cycle while the queue has room.
// Pairs are squared and accumulated; the last pair's distance then passes the queue and
// the back-end states MUL_LO, MUL_HI, SCALE, EXPO, STEP and ROUND, one vector at a time;
// a four-entry queue absorbs short vectors, and the front stalls while three or more distances wait.
// Synchronous reset clears control state and sets inverse_width to 1.0 (Q16.16).
module gaussian_rbf_kernel #(
   parameter int EXP_TABLE_BITS = rbf_pkg::EXP_TABLE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   rbf_req_if.sink                   req_chan,
   rbf_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [rbf_pkg::INV_W-1:0] csr_wr_data
);

   logic [rbf_pkg::INV_W-1:0] inv_width_ff, inv_width_in;
   rbf_pkg::q_push_type       q_push;
   rbf_pkg::q_status_type     q_status;
   logic [rbf_pkg::ACC_W-1:0] q_head;
   logic                      q_pop;

   assign inv_width_in = csr_wr_en ? csr_wr_data : inv_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_width_ff <= rbf_pkg::INV_WIDTH_RESET;
      end else begin
         inv_width_ff <= inv_width_in;
      end
   end

   rbf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .q_push   (q_push)
   );

   rbf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (q_pop),
      .q_status (q_status),
      .head     (q_head)
   );

   rbf_back #(
      .EXP_TABLE_BITS (EXP_TABLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .inv_width (inv_width_ff),
      .q_status  (q_status),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
